@@ src/wmtf_pkg.sv @@
// Shared constants, state encoding and control structs for the weighted MTF stack.
`default_nettype none

package wmtf_pkg;

  // Sizing
  localparam int MAX_ITEMS   = 512;
  localparam int WEIGHT_BITS = 16;
  localparam int ID_W        = 9;
  localparam int ADDR_W      = $clog2(MAX_ITEMS);
  localparam int DEPTH_W     = $clog2(MAX_ITEMS + 1);
  localparam int COST_W      = 25;
  localparam int TOTAL_W     = 48;
  localparam int SUM_W       = ((WEIGHT_BITS > COST_W) ? WEIGHT_BITS : COST_W) + 1;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_ACCESS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_SHIFT,
    ST_PLACE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;
    logic wload_en;
    logic acc_init;
    logic walk_en;
    logic shift_init;
    logic shift_en;
    logic place_en;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic id_ok;
    logic clr_done;
    logic walk_done;
    logic hit;
    logic shift_done;
  } stat_t;

endpackage

`default_nettype wire

@@ src/wmtf_ctrl.sv @@
// Sequencer for the weighted MTF stack: clear pass, load, walk, shift and place.
`default_nettype none

module wmtf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic            in_req_type,
  input  wire wmtf_pkg::stat_t stat,
  output wmtf_pkg::cmd_t       cmd,
  output logic                 busy
);

  wmtf_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wmtf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wmtf_pkg::ST_CLEAR: begin
        if (stat.clr_done) state_nxt = wmtf_pkg::ST_IDLE;
      end
      wmtf_pkg::ST_IDLE: begin
        if (start && stat.id_ok && in_req_type == wmtf_pkg::REQ_ACCESS)
          state_nxt = wmtf_pkg::ST_WALK;
      end
      wmtf_pkg::ST_WALK: begin
        if (stat.walk_done)
          state_nxt = stat.hit ? wmtf_pkg::ST_SHIFT : wmtf_pkg::ST_PLACE;
      end
      wmtf_pkg::ST_SHIFT: begin
        if (stat.shift_done) state_nxt = wmtf_pkg::ST_PLACE;
      end
      wmtf_pkg::ST_PLACE: begin
        state_nxt = wmtf_pkg::ST_IDLE;
      end
      default: state_nxt = wmtf_pkg::ST_CLEAR;
    endcase
  end

  // Commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      wmtf_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      wmtf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && stat.id_ok) begin
          cmd.wload_en = (in_req_type == wmtf_pkg::REQ_LOAD);
          cmd.acc_init = (in_req_type == wmtf_pkg::REQ_ACCESS);
        end
      end
      wmtf_pkg::ST_WALK: begin
        cmd.walk_en    = 1'b1;
        cmd.shift_init = stat.walk_done && stat.hit;
      end
      wmtf_pkg::ST_SHIFT: begin
        cmd.shift_en = 1'b1;
      end
      wmtf_pkg::ST_PLACE: begin
        cmd.place_en = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/wmtf_dp.sv @@
// Datapath: weight and stack memories, walk and shift pipelines, cost and total.
`default_nettype none

module wmtf_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wmtf_pkg::cmd_t                      cmd,
  input  wire logic [wmtf_pkg::ID_W-1:0]           in_item_id,
  input  wire logic [15:0]                         in_weight_value,
  output wmtf_pkg::stat_t                          stat,
  output logic                                     out_valid,
  output logic [wmtf_pkg::COST_W-1:0]              out_access_cost,
  output logic [wmtf_pkg::TOTAL_W-1:0]             out_running_total
);

  localparam int AW = wmtf_pkg::ADDR_W;
  localparam int DW = wmtf_pkg::DEPTH_W;
  localparam int IW = wmtf_pkg::ID_W;
  localparam int WB = wmtf_pkg::WEIGHT_BITS;
  localparam int CW = wmtf_pkg::COST_W;
  localparam int TW = wmtf_pkg::TOTAL_W;
  localparam int SW = wmtf_pkg::SUM_W;
  localparam logic [DW-1:0] DEPTH_MAX = DW'(wmtf_pkg::MAX_ITEMS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(wmtf_pkg::MAX_ITEMS - 1);
  localparam logic [SW-1:0] COST_MAX  = {{(SW-CW){1'b0}}, {CW{1'b1}}};

  // Memories
  logic [WB-1:0] wmem [wmtf_pkg::MAX_ITEMS];
  logic [IW-1:0] smem [wmtf_pkg::MAX_ITEMS];

  logic          w_we;
  logic [AW-1:0] w_wa, w_ra;
  logic [WB-1:0] w_wd, w_q_r;
  logic          s_we;
  logic [AW-1:0] s_wa, s_ra;
  logic [IW-1:0] s_wd, s_q_r;

  // Architectural state
  logic [AW-1:0] clr_cnt_r;
  logic [DW-1:0] depth_r;
  logic [TW-1:0] total_r;
  logic [IW-1:0] id_r;

  // Walk pipeline
  logic [DW-1:0] ptr_r;
  logic          s1_v_r, s2_v_r;
  logic [AW-1:0] s1_a_r;
  logic          hit_r;
  logic [AW-1:0] hit_a_r;
  logic [CW-1:0] acc_r;
  logic          match, issue;
  logic [SW-1:0] acc_sum;
  logic [CW-1:0] acc_sat;

  // Shift pipeline
  logic [DW-1:0] sh_ptr_r;
  logic          sh_pend_r;
  logic [AW-1:0] sh_wa_r;
  logic          sh_issue;

  // Place and result
  logic              room;
  logic [TW:0]       tot_sum;
  logic [TW-1:0]     tot_sat;
  logic              out_valid_r;
  logic [CW-1:0]     out_cost_r;
  logic [TW-1:0]     out_total_r;

  assign match    = s1_v_r && (s_q_r == id_r);
  assign issue    = cmd.walk_en && !hit_r && !match && (ptr_r != '0);
  assign sh_issue = cmd.shift_en && (sh_ptr_r < depth_r);
  assign room     = depth_r < DEPTH_MAX;

  // Saturating cost add
  assign acc_sum = SW'(acc_r) + SW'(w_q_r);
  assign acc_sat = (acc_sum > COST_MAX) ? {CW{1'b1}} : acc_sum[CW-1:0];

  // Saturating total add
  assign tot_sum = {1'b0, total_r} + (TW+1)'(acc_r);
  assign tot_sat = tot_sum[TW] ? {TW{1'b1}} : tot_sum[TW-1:0];

  // Weight memory port selection
  always_comb begin
    w_we = cmd.clr_en || cmd.wload_en;
    w_wa = cmd.clr_en ? clr_cnt_r : AW'(in_item_id);
    w_wd = cmd.clr_en ? '0 : in_weight_value[WB-1:0];
    w_ra = AW'(s_q_r);
  end

  // Stack memory port selection
  always_comb begin
    s_ra = cmd.shift_en ? AW'(sh_ptr_r) : AW'(ptr_r - DW'(1));
    s_we = 1'b0;
    s_wa = sh_wa_r;
    s_wd = s_q_r;
    if (cmd.shift_en && sh_pend_r) begin
      s_we = 1'b1;
    end else if (cmd.place_en && (hit_r || room)) begin
      s_we = 1'b1;
      s_wa = hit_r ? AW'(depth_r - DW'(1)) : AW'(depth_r);
      s_wd = id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    w_q_r <= wmem[w_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_wa] <= s_wd;
    s_q_r <= smem[s_ra];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      depth_r     <= '0;
      total_r     <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      hit_r       <= 1'b0;
      sh_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.place_en;
      if (cmd.clr_en) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.acc_init) begin
        s1_v_r <= 1'b0;
        s2_v_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (cmd.walk_en) begin
        s1_v_r <= issue;
        s2_v_r <= s1_v_r && !match;
        if (match) hit_r <= 1'b1;
      end
      if (cmd.shift_init) sh_pend_r <= 1'b0;
      else if (cmd.shift_en) sh_pend_r <= sh_issue;
      if (cmd.place_en) begin
        total_r <= tot_sat;
        if (!hit_r && room) depth_r <= depth_r + DW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.acc_init) begin
      id_r  <= in_item_id;
      ptr_r <= depth_r;
      acc_r <= '0;
    end else if (cmd.walk_en) begin
      if (issue) begin
        ptr_r  <= ptr_r - DW'(1);
        s1_a_r <= AW'(ptr_r - DW'(1));
      end
      if (match) hit_a_r <= s1_a_r;
      if (s2_v_r) acc_r <= acc_sat;
    end
    if (cmd.shift_init) begin
      sh_ptr_r <= DW'(hit_a_r) + DW'(1);
    end else if (sh_issue) begin
      sh_ptr_r <= sh_ptr_r + DW'(1);
      sh_wa_r  <= AW'(sh_ptr_r - DW'(1));
    end
    if (cmd.place_en) begin
      out_cost_r  <= acc_r;
      out_total_r <= tot_sat;
    end
  end

  // Status
  always_comb begin
    stat.id_ok      = 32'(in_item_id) < 32'(wmtf_pkg::MAX_ITEMS);
    stat.clr_done   = clr_cnt_r == LAST_ADDR;
    stat.walk_done  = !s1_v_r && !s2_v_r && (hit_r || ptr_r == '0);
    stat.hit        = hit_r;
    stat.shift_done = !sh_pend_r && (sh_ptr_r >= depth_r);
  end

  assign out_valid         = out_valid_r;
  assign out_access_cost   = out_cost_r;
  assign out_running_total = out_total_r;

endmodule

`default_nettype wire

@@ src/weighted_move_to_front_stack.sv @@
// Sequence: a load word is written to the weight table as it is accepted. An access walks
//   the stack from the top, summing weights until its item is met; on a hit it shifts the
//   entries above that item down by one, then places the item on top (on a miss only if the
//   stack has room) and strobes its result the cycle after. Walk and shift share one read port.
// Throughput: the next word is taken in the strobe cycle; the receiver cannot stall.
// Reset: synchronous; then all MAX_ITEMS (512) weight entries are swept to zero, busy high.
`default_nettype none

module weighted_move_to_front_stack (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_req_type,
  input  wire logic [8:0]                          in_item_id,
  input  wire logic [15:0]                         in_weight_value,
  output logic                                     out_valid,
  output logic [24:0]                              out_access_cost,
  output logic [47:0]                              out_running_total
);

  wmtf_pkg::cmd_t  cmd;
  wmtf_pkg::stat_t stat;

  wmtf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  wmtf_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_item_id        (in_item_id),
    .in_weight_value   (in_weight_value),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_access_cost   (out_access_cost),
    .out_running_total (out_running_total)
  );

`ifndef NO_ASSERTIONS
  // Clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // A result word follows an access in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without an access in progress");

  // One strobe per access
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Running total includes this access
  a_total_ge_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_running_total >= 48'(out_access_cost)))
    else $error("running total below access cost");
`endif

endmodule

`default_nettype wire

@@ tb/weighted_move_to_front_stack_tb.sv @@
`timescale 1ns / 100ps
// Testbench for the weighted move-to-front stack: a directed table, then random words.
module weighted_move_to_front_stack_tb;

  localparam int RANDOM_WORDS = 560;
  localparam int HOT_IDS      = 12;
  localparam int REPORT_LIMIT = 10;
  // Longest access: full walk plus full shift, with margin
  localparam int DRAIN_CYCLES = 2 * wmtf_pkg::MAX_ITEMS + 32;

  localparam logic [wmtf_pkg::COST_W-1:0]  COST_SAT  = '1;
  localparam logic [wmtf_pkg::TOTAL_W-1:0] TOTAL_SAT = '1;

  // Short names for the request codes in the table rows
  localparam logic ROW_LOAD   = wmtf_pkg::REQ_LOAD;
  localparam logic ROW_ACCESS = wmtf_pkg::REQ_ACCESS;

  typedef struct packed {
    logic [wmtf_pkg::COST_W-1:0]  cost;
    logic [wmtf_pkg::TOTAL_W-1:0] total;
  } access_result_t;

  // One row of the directed table; cost and total only count where checked is set
  typedef struct packed {
    logic                             req;
    logic [wmtf_pkg::ID_W-1:0]        id;
    logic [wmtf_pkg::WEIGHT_BITS-1:0] weight;
    logic                             checked;
    logic [wmtf_pkg::COST_W-1:0]      cost;
    logic [wmtf_pkg::TOTAL_W-1:0]     total;
  } stim_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  wire                              busy;
  logic                             in_req_type;
  logic [wmtf_pkg::ID_W-1:0]        in_item_id;
  logic [wmtf_pkg::WEIGHT_BITS-1:0] in_weight_value;
  wire                              out_valid;
  wire  [wmtf_pkg::COST_W-1:0]      out_access_cost;
  wire  [wmtf_pkg::TOTAL_W-1:0]     out_running_total;

  // Hand-worked expectation travelling with the current word
  logic                             word_has_ref;
  logic [wmtf_pkg::COST_W-1:0]      word_ref_cost;
  logic [wmtf_pkg::TOTAL_W-1:0]     word_ref_total;

  // Predictor state
  logic [wmtf_pkg::WEIGHT_BITS-1:0] weight_tab [wmtf_pkg::MAX_ITEMS];
  logic [wmtf_pkg::ID_W-1:0]        recency [$];  // back of the queue is the top of the stack
  logic [wmtf_pkg::TOTAL_W-1:0]     run_total;

  access_result_t                   pending_results [$];
  int                               fail_count;
  bit                               burst_mode;

  weighted_move_to_front_stack DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_item_id        (in_item_id),
    .in_weight_value   (in_weight_value),
    .out_valid         (out_valid),
    .out_access_cost   (out_access_cost),
    .out_running_total (out_running_total)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic flag_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endtask

  // Walk from the top summing weights until the id is met, then bring it to the top
  function automatic access_result_t mtf_access(input logic [wmtf_pkg::ID_W-1:0] id);
    longint unsigned cost;
    longint unsigned sum;
    int              pos;
    access_result_t  res;
    cost = 0;
    pos  = -1;
    for (int i = recency.size() - 1; i >= 0; i--) begin
      if (recency[i] == id) begin
        pos = i;
        break;
      end
      cost += weight_tab[recency[i]];
    end
    if (pos >= 0) recency.delete(pos);
    if (recency.size() < wmtf_pkg::MAX_ITEMS) recency.insert(recency.size(), id);
    if (cost > COST_SAT) cost = COST_SAT;
    sum = run_total + cost;
    if (sum > TOTAL_SAT) sum = TOTAL_SAT;
    run_total  = wmtf_pkg::TOTAL_W'(sum);
    res.cost   = wmtf_pkg::COST_W'(cost);
    res.total  = wmtf_pkg::TOTAL_W'(sum);
    return res;
  endfunction

  // Result check first, then the word accepted at this edge
  always @(posedge clk) begin : scoreboard
    access_result_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          flag_failure($sformatf("unexpected result: cost %0d total %0d",
                                 out_access_cost, out_running_total));
        end else begin
          want = pending_results.pop_front();
          if (out_access_cost !== want.cost)
            flag_failure($sformatf("access_cost: expected %0d, got %0d",
                                   want.cost, out_access_cost));
          if (out_running_total !== want.total)
            flag_failure($sformatf("running_total: expected %0d, got %0d",
                                   want.total, out_running_total));
        end
      end else if (out_valid !== 1'b0) begin
        flag_failure("out_valid is unknown");
      end

      if (start && busy === 1'b0) begin
        if (in_req_type == wmtf_pkg::REQ_LOAD) begin
          weight_tab[in_item_id] = in_weight_value;
        end else begin
          want = mtf_access(in_item_id);
          if (word_has_ref) begin
            want.cost  = word_ref_cost;
            want.total = word_ref_total;
          end
          pending_results.insert(pending_results.size(), want);
        end
      end
    end
  end

  // Present one word after a random gap and hold it until taken
  task automatic send_word(input logic req, input logic [wmtf_pkg::ID_W-1:0] id,
                           input logic [wmtf_pkg::WEIGHT_BITS-1:0] w, input logic has_ref,
                           input logic [wmtf_pkg::COST_W-1:0] ref_cost,
                           input logic [wmtf_pkg::TOTAL_W-1:0] ref_total);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= req;
    in_item_id      <= id;
    in_weight_value <= w;
    word_has_ref    <= has_ref;
    word_ref_cost   <= ref_cost;
    word_ref_total  <= ref_total;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  initial begin : stimulus
    stim_row_t                        directed_rows [0:20];
    logic [wmtf_pkg::ID_W-1:0]        hot_ids [HOT_IDS];
    logic                             req;
    logic [wmtf_pkg::ID_W-1:0]        id;
    logic [wmtf_pkg::WEIGHT_BITS-1:0] w;
    int                               sel;

    start           = 1'b0;
    rst_n           = 1'b0;
    in_req_type     = wmtf_pkg::REQ_LOAD;
    in_item_id      = '0;
    in_weight_value = '0;
    word_has_ref    = 1'b0;
    word_ref_cost   = '0;
    word_ref_total  = '0;
    fail_count      = 0;
    burst_mode      = 1'b0;
    run_total       = '0;
    foreach (weight_tab[i]) weight_tab[i] = '0;

    // Access words carry junk weights: they must not be stored
    directed_rows = '{
      '{ROW_ACCESS, 9'd0,   16'hFFFF, 1'b1, 25'd0,      48'd0},      // first access, empty
      '{ROW_LOAD,   9'd0,   16'hFFFF, 1'b0, 25'd0,      48'd0},
      '{ROW_LOAD,   9'd511, 16'hFFFF, 1'b0, 25'd0,      48'd0},
      '{ROW_ACCESS, 9'd511, 16'h0000, 1'b1, 25'd65535,  48'd65535},  // miss sums all
      '{ROW_ACCESS, 9'd0,   16'hFFFF, 1'b1, 25'd65535,  48'd131070}, // bottom of two
      '{ROW_ACCESS, 9'd0,   16'h0000, 1'b1, 25'd0,      48'd131070}, // already on top
      '{ROW_LOAD,   9'd511, 16'h0001, 1'b0, 25'd0,      48'd0},      // reweight in stack
      '{ROW_ACCESS, 9'd511, 16'hFFFF, 1'b1, 25'd65535,  48'd196605},
      '{ROW_ACCESS, 9'd0,   16'h0000, 1'b1, 25'd1,      48'd196606},
      '{ROW_LOAD,   9'd256, 16'h5555, 1'b0, 25'd0,      48'd0},
      '{ROW_LOAD,   9'd170, 16'hAAAA, 1'b0, 25'd0,      48'd0},
      '{ROW_ACCESS, 9'd170, 16'hFFFF, 1'b1, 25'd65536,  48'd262142},
      '{ROW_ACCESS, 9'd256, 16'h0000, 1'b1, 25'd109226, 48'd371368},
      '{ROW_ACCESS, 9'd511, 16'hFFFF, 1'b1, 25'd131070, 48'd502438}, // bottom of four
      '{ROW_ACCESS, 9'd170, 16'h0000, 1'b1, 25'd21846,  48'd524284}, // middle
      '{ROW_LOAD,   9'd0,   16'h0000, 1'b0, 25'd0,      48'd0},
      '{ROW_ACCESS, 9'd0,   16'hFFFF, 1'b1, 25'd65536,  48'd589820},
      '{ROW_LOAD,   9'd1,   16'h8000, 1'b0, 25'd0,      48'd0},
      '{ROW_ACCESS, 9'd1,   16'h1234, 1'b0, 25'd0,      48'd0},
      '{ROW_ACCESS, 9'd256, 16'hFFFF, 1'b0, 25'd0,      48'd0},
      '{ROW_LOAD,   9'd511, 16'hFFFF, 1'b0, 25'd0,      48'd0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (directed_rows[r])
      send_word(directed_rows[r].req, directed_rows[r].id, directed_rows[r].weight,
                directed_rows[r].checked, directed_rows[r].cost, directed_rows[r].total);

    // Random words: a small hot set keeps the stack shallow and hits near the top,
    // the rest spread over the whole id range and slowly deepen the stack
    foreach (hot_ids[i])
      hot_ids[i] = wmtf_pkg::ID_W'($urandom_range(0, wmtf_pkg::MAX_ITEMS - 1));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      req = ($urandom_range(0, 99) < 28) ? wmtf_pkg::REQ_LOAD : wmtf_pkg::REQ_ACCESS;
      if ($urandom_range(0, 99) < 55) id = hot_ids[$urandom_range(0, HOT_IDS - 1)];
      else id = wmtf_pkg::ID_W'($urandom_range(0, wmtf_pkg::MAX_ITEMS - 1));
      sel = $urandom_range(0, 9);
      if (sel == 0)      w = '0;
      else if (sel == 1) w = '1;
      else               w = wmtf_pkg::WEIGHT_BITS'($urandom_range(0, 65535));
      send_word(req, id, w, 1'b0, '0, '0);
    end
    start <= 1'b0;

    // Drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else                 $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/wmtf_pkg.sv
src/wmtf_ctrl.sv
src/wmtf_dp.sv
src/weighted_move_to_front_stack.sv
tb/weighted_move_to_front_stack_tb.sv
